FILE: design/jfi_pkg.sv
// ----------------------------------------------------------------------------
// jfi_pkg
// Shared types and constants for the 8x8 fast integer IDCT unit.
// ----------------------------------------------------------------------------
package jfi_pkg;

    localparam int BLK_SIZE   = 64;
    localparam int DQ_DEPTH   = 2 * BLK_SIZE;
    localparam int DQ_AW      = $clog2(DQ_DEPTH);
    localparam int PS_AW      = $clog2(BLK_SIZE);
    localparam int WORD_W     = 16;

    localparam logic signed [10:0] K_R2   = 11'sd362;
    localparam logic signed [10:0] K_C8X2 = 11'sd473;
    localparam logic signed [10:0] K_A    = 11'sd277;
    localparam logic signed [10:0] K_B    = -11'sd669;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic avail;
        logic bank;
    } fq_status_t;

    typedef struct packed {
        logic            we;
        logic [DQ_AW-1:0] addr;
        word_t           data;
    } dq_wr_t;

endpackage

FILE: design/jfi_ram.sv
// ----------------------------------------------------------------------------
// jfi_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module jfi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/jfi_front.sv
// ----------------------------------------------------------------------------
// jfi_front
// Accepts coefficient beats, dequantizes them and fills two block banks.
// Tracks how many filled banks wait for the transform.
// ----------------------------------------------------------------------------
module jfi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  jfi_pkg::word_t      coef_value,
    input  jfi_pkg::word_t      quant_mult,
    input  logic                release_bank,
    output jfi_pkg::dq_wr_t     dq_wr,
    output jfi_pkg::fq_status_t status
);
    import jfi_pkg::*;

    logic [PS_AW-1:0] load_cnt_reg, load_cnt_next;
    logic             wr_bank_reg, wr_bank_next;
    logic             rd_bank_reg, rd_bank_next;
    logic [1:0]       full_cnt_reg, full_cnt_next;
    logic             accept, push;
    logic signed [31:0] prod;

    assign in_stall = (full_cnt_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (load_cnt_reg == PS_AW'(BLK_SIZE - 1));
    assign prod     = coef_value * quant_mult;

    assign dq_wr.we   = accept;
    assign dq_wr.addr = {wr_bank_reg, load_cnt_reg};
    assign dq_wr.data = prod[WORD_W-1:0];

    assign status.avail = (full_cnt_reg != 2'd0);
    assign status.bank  = rd_bank_reg;

    always_comb
    begin
        load_cnt_next = accept ? load_cnt_reg + PS_AW'(1) : load_cnt_reg;
        wr_bank_next  = push ? !wr_bank_reg : wr_bank_reg;
        rd_bank_next  = release_bank ? !rd_bank_reg : rd_bank_reg;
        full_cnt_next = full_cnt_reg + {1'b0, push} - {1'b0, release_bank};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            wr_bank_reg  <= 1'b0;
            rd_bank_reg  <= 1'b0;
            full_cnt_reg <= 2'd0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            wr_bank_reg  <= wr_bank_next;
            rd_bank_reg  <= rd_bank_next;
            full_cnt_reg <= full_cnt_next;
        end
    end

endmodule

FILE: design/jfi_back.sv
// ----------------------------------------------------------------------------
// jfi_back
// Transform sequencer: column pass then row pass through one two-stage
// 8-point IDCT unit, then pixel beats with range limiting.
// ----------------------------------------------------------------------------
module jfi_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  jfi_pkg::fq_status_t       status,
    output logic                      release_bank,
    output logic [jfi_pkg::DQ_AW-1:0] dq_raddr,
    input  jfi_pkg::word_t            dq_rdata,
    output logic                      ps_we,
    output logic [jfi_pkg::PS_AW-1:0] ps_waddr,
    output jfi_pkg::word_t            ps_wdata,
    output logic [jfi_pkg::PS_AW-1:0] ps_raddr,
    input  jfi_pkg::word_t            ps_rdata,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                pixel,
    output logic                      last_pixel
);
    import jfi_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLOAD  = 9'b000000010,
        S_CCALC1 = 9'b000000100,
        S_CCALC2 = 9'b000001000,
        S_CSTORE = 9'b000010000,
        S_RLOAD  = 9'b000100000,
        S_RCALC1 = 9'b001000000,
        S_RCALC2 = 9'b010000000,
        S_ROUT   = 9'b100000000
    } state_t;

    typedef struct packed {
        word_t t10, t11, t13, m12, q7, q11, z5, ma, mb;
    } s1_t;

    function automatic word_t mulc(input word_t a, input logic signed [10:0] k);
        logic signed [26:0] p;
        begin
            p = a * k;
            return p[23:8];
        end
    endfunction

    state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] line_reg, line_next;
    word_t      x_reg [8];
    word_t      y_reg [8];
    word_t      y_next [8];
    s1_t        s1_reg, s1_next;
    logic [3:0] cm1;
    word_t      ld_data;
    word_t      z10, z11, z12, z13;
    word_t      t12, p0, p1, p2, p3, q4, q5, q6, q10, q12;
    word_t      yo;
    logic signed [11:0] v;
    logic       loading;

    assign cm1     = cnt_reg - 4'd1;
    assign loading = (state_reg == S_CLOAD) || (state_reg == S_RLOAD);
    assign ld_data = (state_reg == S_CLOAD) ? dq_rdata : ps_rdata;

    assign dq_raddr = {status.bank, cnt_reg[2:0], line_reg};
    assign ps_raddr = {line_reg, cnt_reg[2:0]};
    assign ps_waddr = {cnt_reg[2:0], line_reg};
    assign ps_wdata = y_reg[cnt_reg[2:0]];
    assign ps_we    = (state_reg == S_CSTORE);
    assign release_bank = (state_reg == S_CSTORE) && (cnt_reg == 4'd7) &&
                          (line_reg == 3'd7);

    always_comb
    begin
        z13 = x_reg[5] + x_reg[3];
        z10 = x_reg[5] - x_reg[3];
        z11 = x_reg[1] + x_reg[7];
        z12 = x_reg[1] - x_reg[7];
        s1_next.t10 = x_reg[0] + x_reg[4];
        s1_next.t11 = x_reg[0] - x_reg[4];
        s1_next.t13 = x_reg[2] + x_reg[6];
        s1_next.m12 = mulc(x_reg[2] - x_reg[6], K_R2);
        s1_next.q7  = z11 + z13;
        s1_next.q11 = mulc(z11 - z13, K_R2);
        s1_next.z5  = mulc(z10 + z12, K_C8X2);
        s1_next.ma  = mulc(z12, K_A);
        s1_next.mb  = mulc(z10, K_B);
    end

    always_comb
    begin
        t12 = s1_reg.m12 - s1_reg.t13;
        p0  = s1_reg.t10 + s1_reg.t13;
        p3  = s1_reg.t10 - s1_reg.t13;
        p1  = s1_reg.t11 + t12;
        p2  = s1_reg.t11 - t12;
        q10 = s1_reg.ma - s1_reg.z5;
        q12 = s1_reg.mb + s1_reg.z5;
        q6  = q12 - s1_reg.q7;
        q5  = s1_reg.q11 - q6;
        q4  = q10 + q5;
        y_next[0] = p0 + s1_reg.q7;
        y_next[7] = p0 - s1_reg.q7;
        y_next[1] = p1 + q6;
        y_next[6] = p1 - q6;
        y_next[2] = p2 + q5;
        y_next[5] = p2 - q5;
        y_next[4] = p3 + q4;
        y_next[3] = p3 - q4;
    end

    assign yo  = y_reg[cnt_reg[2:0]];
    assign v   = {yo[15], yo[15:5]} + 12'sd128;
    assign out_valid  = (state_reg == S_ROUT);
    assign last_pixel = (cnt_reg == 4'd7) && (line_reg == 3'd7);

    always_comb
    begin
        if (v < 12'sd0)
        begin
            pixel = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            pixel = 8'd255;
        end
        else
        begin
            pixel = v[7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next  = 4'd0;
                line_next = 3'd0;
                if (status.avail)
                begin
                    state_next = S_CLOAD;
                end
            end
            S_CLOAD, S_RLOAD:
            begin
                if (cnt_reg == 4'd8)
                begin
                    cnt_next   = 4'd0;
                    state_next = (state_reg == S_CLOAD) ? S_CCALC1 : S_RCALC1;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_CCALC1: state_next = S_CCALC2;
            S_CCALC2: state_next = S_CSTORE;
            S_RCALC1: state_next = S_RCALC2;
            S_RCALC2: state_next = S_ROUT;
            S_CSTORE:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7)
                begin
                    cnt_next   = 4'd0;
                    line_next  = line_reg + 3'd1;
                    state_next = (line_reg == 3'd7) ? S_RLOAD : S_CLOAD;
                end
            end
            S_ROUT:
            begin
                if (!out_stall)
                begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd7)
                    begin
                        cnt_next   = 4'd0;
                        line_next  = line_reg + 3'd1;
                        state_next = (line_reg == 3'd7) ? S_IDLE : S_RLOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 4'd0;
            line_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (loading && (cnt_reg != 4'd0))
        begin
            x_reg[cm1[2:0]] <= ld_data;
        end
        if ((state_reg == S_CCALC1) || (state_reg == S_RCALC1))
        begin
            s1_reg <= s1_next;
        end
        if ((state_reg == S_CCALC2) || (state_reg == S_RCALC2))
        begin
            y_reg <= y_next;
        end
    end

endmodule

FILE: design/jpeg_fast_idct_8x8_unit.sv
// ----------------------------------------------------------------------------
// jpeg_fast_idct_8x8_unit
// 8x8 fast integer IDCT with dequantization and double-buffered loading.
// ----------------------------------------------------------------------------
// Loading takes one coefficient beat per cycle, unless stalled, into one
// of two dequantized banks, so a block loads while the previous one is
// transformed; the input stalls only when both banks are full. The transform
// sequencer owns one 8-point unit and one read port per store: each of the 16
// lines is read in, computed and then written back or sent out as pixels,
// and output stalls hold the row pass. Pixels leave row-major, last_pixel
// on the 64th.
module jpeg_fast_idct_8x8_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  jfi_pkg::word_t       coef_value,
    input  jfi_pkg::word_t       quant_mult,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           pixel,
    output logic                 last_pixel
);
    import jfi_pkg::*;

    dq_wr_t           dq_wr;
    fq_status_t       status;
    logic             release_bank;
    logic [DQ_AW-1:0] dq_raddr;
    word_t            dq_rdata;
    logic             ps_we;
    logic [PS_AW-1:0] ps_waddr, ps_raddr;
    word_t            ps_wdata, ps_rdata;

    jfi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coef_value   (coef_value),
        .quant_mult   (quant_mult),
        .release_bank (release_bank),
        .dq_wr        (dq_wr),
        .status       (status)
    );

    jfi_ram #(.WIDTH(WORD_W), .DEPTH(DQ_DEPTH)) u_dq_ram (
        .clk   (clk),
        .we    (dq_wr.we),
        .waddr (dq_wr.addr),
        .wdata (dq_wr.data),
        .raddr (dq_raddr),
        .rdata (dq_rdata)
    );

    jfi_ram #(.WIDTH(WORD_W), .DEPTH(BLK_SIZE)) u_ps_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .raddr (ps_raddr),
        .rdata (ps_rdata)
    );

    jfi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .release_bank (release_bank),
        .dq_raddr     (dq_raddr),
        .dq_rdata     (dq_rdata),
        .ps_we        (ps_we),
        .ps_waddr     (ps_waddr),
        .ps_wdata     (ps_wdata),
        .ps_raddr     (ps_raddr),
        .ps_rdata     (ps_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel        (pixel),
        .last_pixel   (last_pixel)
    );

    a_rel_needs_bank: assert property (@(posedge clk) disable iff (!rst_n)
        release_bank |-> status.avail)
        else $error("bank released with none full");

    a_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_pixel) |=> !out_valid)
        else $error("pixel beat after end of block");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !release_bank) |=> in_stall)
        else $error("input freed without a bank release");

endmodule

FILE: test/tb_jpeg_fast_idct_8x8_unit.sv
// ----------------------------------------------------------------------------
// tb_jpeg_fast_idct_8x8_unit
// Streams blocks of coefficient and multiplier beats into the IDCT unit with
// random bursts and output stalls, predicts each block's 64 pixels with an
// independent 16-bit fast IDCT and checks every pixel beat in order.
// ----------------------------------------------------------------------------
class idct_pixel_board;
    logic signed [15:0] dq_block [64];
    int                 fill_pos;
    logic [8:0]         pixel_q [$];
    int                 errors;

    function new();
        fill_pos = 0;
        errors   = 0;
    endfunction

    static function logic signed [15:0] kmul(logic signed [15:0] a, int k);
        int p;
        p = int'(a) * k;
        return 16'(p >>> 8);
    endfunction

    static function void line8(input logic signed [15:0] x [8],
                               output logic signed [15:0] y [8]);
        logic signed [15:0] t10, t11, t12, t13, p0, p1, p2, p3;
        logic signed [15:0] z5, z10, z11, z12, z13, q4, q5, q6, q7, q10, q11, q12;
        t10 = x[0] + x[4];
        t11 = x[0] - x[4];
        t13 = x[2] + x[6];
        t12 = kmul(16'(x[2] - x[6]), 362) - t13;
        p0 = t10 + t13;
        p3 = t10 - t13;
        p1 = t11 + t12;
        p2 = t11 - t12;
        z13 = x[5] + x[3];
        z10 = x[5] - x[3];
        z11 = x[1] + x[7];
        z12 = x[1] - x[7];
        q7  = z11 + z13;
        q11 = kmul(16'(z11 - z13), 362);
        z5  = kmul(16'(z10 + z12), 473);
        q10 = kmul(z12, 277) - z5;
        q12 = kmul(z10, -669) + z5;
        q6 = q12 - q7;
        q5 = q11 - q6;
        q4 = q10 + q5;
        y[0] = p0 + q7;
        y[7] = p0 - q7;
        y[1] = p1 + q6;
        y[6] = p1 - q6;
        y[2] = p2 + q5;
        y[5] = p2 - q5;
        y[4] = p3 + q4;
        y[3] = p3 - q4;
    endfunction

    function void note_coef(logic signed [15:0] c, logic signed [15:0] q);
        logic signed [15:0] cols [64];
        logic signed [15:0] x [8];
        logic signed [15:0] y [8];
        int v;
        dq_block[fill_pos] = 16'(int'(c) * int'(q));
        fill_pos = (fill_pos + 1) % 64;
        if (fill_pos != 0)
            return;
        for (int k = 0; k < 8; k++)
        begin
            for (int r = 0; r < 8; r++)
                x[r] = dq_block[r*8+k];
            line8(x, y);
            for (int r = 0; r < 8; r++)
                cols[r*8+k] = y[r];
        end
        for (int r = 0; r < 8; r++)
        begin
            for (int k = 0; k < 8; k++)
                x[k] = cols[r*8+k];
            line8(x, y);
            for (int k = 0; k < 8; k++)
            begin
                v = (int'(y[k]) >>> 5) + 128;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                pixel_q.push_back({(r == 7 && k == 7), 8'(v)});
            end
        end
    endfunction

    function void check_pixel(logic [7:0] px, logic lst);
        logic [8:0] e;
        if (pixel_q.size() == 0)
        begin
            $display("%0t: unexpected pixel beat %0d last %0b", $time, px, lst);
            errors++;
            return;
        end
        e = pixel_q.pop_front();
        if (e[7:0] !== px)
        begin
            $display("%0t: pixel expected %0d actual %0d", $time, e[7:0], px);
            errors++;
        end
        if (e[8] !== lst)
        begin
            $display("%0t: last_pixel expected %0b actual %0b", $time, e[8], lst);
            errors++;
        end
    endfunction
endclass

module tb_jpeg_fast_idct_8x8_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    jfi_pkg::word_t     coef_value;
    jfi_pkg::word_t     quant_mult;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         pixel;
    logic               last_pixel;

    idct_pixel_board board;
    int              stall_mode;

    jpeg_fast_idct_8x8_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .coef_value (coef_value),
        .quant_mult (quant_mult),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel      (pixel),
        .last_pixel (last_pixel)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("jpeg_fast_idct_8x8_unit test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_pixel(pixel, last_pixel);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 3);

    // hold each beat until accepted; valid stays high across a burst
    task automatic send_coef(logic signed [15:0] c, logic signed [15:0] q);
        in_valid   <= 1'b1;
        coef_value <= c;
        quant_mult <= q;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_coef(c, q);
    endtask

    task automatic send_block(int kind);
        logic signed [15:0] c, q;
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < 64; i++)
        begin
            case (kind)
                0:
                begin
                    c = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
                    q = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
                end
                1:
                begin
                    c = (i == 0) ? 16'($urandom_range(0, 2047)) - 16'sd1024 : 16'sd0;
                    q = 16'($urandom_range(1, 8));
                end
                2:
                begin
                    c = 16'($urandom_range(0, 511)) - 16'sd256;
                    q = 16'($urandom_range(1, 16));
                end
                default:
                begin
                    c = 16'($urandom);
                    q = 16'($urandom);
                end
            endcase
            if (burst == 0)
                burst = $urandom_range(1, 40);
            burst--;
            send_coef(c, q);
            if (burst == 0)
            begin
                gap = $urandom_range(0, 4);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        board      = new();
        stall_mode = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        coef_value = '0;
        quant_mult = '0;
        out_stall  = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < 3; k++)
            send_block(k);
        in_valid <= 1'b0;
        while (board.pixel_q.size() != 0)
            @(posedge clk);
        for (int b = 0; b < 2; b++)
            send_block($urandom_range(0, 1) ? 2 : 3);
        in_valid <= 1'b0;
        fork
        begin
            while (board.pixel_q.size() != 0)
                @(posedge clk);
            repeat (400)
                @(posedge clk);
            if (board.errors == 0)
                $display("jpeg_fast_idct_8x8_unit test passed");
            else
                $display("jpeg_fast_idct_8x8_unit test failed");
            $finish;
        end
        join
    end
endmodule

FILE: filelist.f
design/jfi_pkg.sv
design/jfi_ram.sv
design/jfi_front.sv
design/jfi_back.sv
design/jpeg_fast_idct_8x8_unit.sv
test/tb_jpeg_fast_idct_8x8_unit.sv
